@@ rtl/bps_pkg.sv @@
package bps_pkg;

    localparam int VEC_W    = 20;   // interpolated and difference vectors, signed
    localparam int UNIT_W   = 16;   // unit vector components, signed Q.14
    localparam int FRAC_W   = 14;
    localparam int COMP_W   = 16;
    localparam int WGT_W    = 16;
    localparam int TEX_W    = 24;
    localparam int CH_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;
    localparam int CORNERS  = 3;

    localparam logic signed [COMP_W-1:0] EYE_RST   = 16'sd0;
    localparam logic signed [COMP_W-1:0] LIGHT_RST = 16'sd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EYE_X   = 3'd0,
        CFG_EYE_Y   = 3'd1,
        CFG_EYE_Z   = 3'd2,
        CFG_LIGHT_X = 3'd3,
        CFG_LIGHT_Y = 3'd4,
        CFG_LIGHT_Z = 3'd5
    } t_cfg_idx;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

endpackage

@@ rtl/bps_unit.sv @@
module bps_unit #(
    parameter int VW = bps_pkg::VEC_W,
    parameter int PW = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [2:0][VW-1:0]                  i_vec,
    input  logic [PW-1:0]                       i_pay,
    output logic                                o_valid,
    output logic [2:0][bps_pkg::UNIT_W-1:0]     o_vec,
    output logic [PW-1:0]                       o_pay
);
    localparam int SW = 2 * VW;
    localparam int RW = VW;
    localparam int FB = bps_pkg::FRAC_W;
    localparam int QB = FB + 1;
    localparam int DW = VW + FB;
    localparam int UW = bps_pkg::UNIT_W;

    // squares
    logic [2:0][SW-1:0] r_sq;
    logic [2:0][VW-1:0] r_avec;
    logic [PW-1:0]      r_apay;
    logic               r_av;

    // square root, index 0 holds the sum
    logic [RW+1:0]      r_rem  [RW+1];
    logic [RW-1:0]      r_root [RW+1];
    logic [SW-1:0]      r_val  [RW+1];
    logic [2:0][VW-1:0] r_svec [RW+1];
    logic [PW-1:0]      r_spay [RW+1];
    logic [RW:0]        r_sv;

    // division, index 0 is set-up
    logic [2:0][DW-1:0] r_drem [QB+1];
    logic [2:0][QB-1:0] r_dq   [QB+1];
    logic [2:0]         r_dsg  [QB+1];
    logic [RW-1:0]      r_dl   [QB+1];
    logic [PW-1:0]      r_dpay [QB+1];
    logic [QB:0]        r_dv;

    logic [2:0][UW-1:0] r_ovec;
    logic [PW-1:0]      r_opay;
    logic               r_ov;

    logic [RW+1:0]      n_rem2  [RW+1];
    logic [RW+1:0]      n_trial [RW+1];
    logic [RW:0]        n_ge;
    logic [2:0][DW-1:0] n_dsub  [QB+1];
    logic [2:0]         n_dge   [QB+1];
    logic [DW-1:0]      n_div   [QB+1];

    always_comb begin
        n_rem2[0]  = '0;
        n_trial[0] = '0;
        n_ge[0]    = 1'b0;
        for (int j = 1; j <= RW; j++) begin
            n_rem2[j]  = {r_rem[j-1][RW-1:0], r_val[j-1][SW-1 -: 2]};
            n_trial[j] = {r_root[j-1], 2'b01};
            n_ge[j]    = n_rem2[j] >= n_trial[j];
        end
        n_dsub[0] = '0;
        n_dge[0]  = '0;
        n_div[0]  = '0;
        for (int k = 1; k <= QB; k++) begin
            n_div[k] = DW'(r_dl[k-1]) << (QB - k);
            for (int i = 0; i < 3; i++) begin
                n_dge[k][i]  = r_drem[k-1][i] >= n_div[k];
                n_dsub[k][i] = r_drem[k-1][i] - n_div[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_sv <= '0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_av <= i_valid;
            r_sv <= {r_sv[RW-1:0], r_av};
            r_dv <= {r_dv[QB-1:0], r_sv[RW]};
            r_ov <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SW'($signed(SW'($signed(i_vec[i])) * SW'($signed(i_vec[i]))));
            end
            r_avec <= i_vec;
            r_apay <= i_pay;

            r_val[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_svec[0] <= r_avec;
            r_spay[0] <= r_apay;
            for (int j = 1; j <= RW; j++) begin
                r_rem[j]  <= n_ge[j] ? (n_rem2[j] - n_trial[j]) : n_rem2[j];
                r_root[j] <= {r_root[j-1][RW-2:0], n_ge[j]};
                r_val[j]  <= r_val[j-1] << 2;
                r_svec[j] <= r_svec[j-1];
                r_spay[j] <= r_spay[j-1];
            end

            for (int i = 0; i < 3; i++) begin
                r_dsg[0][i]  <= r_svec[RW][i][VW-1];
                r_drem[0][i] <= {(r_svec[RW][i][VW-1] ? (~r_svec[RW][i] + 1'b1)
                                                       : r_svec[RW][i]), {FB{1'b0}}};
            end
            r_dq[0]   <= '0;
            r_dl[0]   <= r_root[RW];
            r_dpay[0] <= r_spay[RW];
            for (int k = 1; k <= QB; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[k][i] <= n_dge[k][i] ? n_dsub[k][i] : r_drem[k-1][i];
                    r_dq[k][i]   <= r_dq[k-1][i] | (QB'(n_dge[k][i]) << (QB - k));
                end
                r_dsg[k]  <= r_dsg[k-1];
                r_dl[k]   <= r_dl[k-1];
                r_dpay[k] <= r_dpay[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                if (r_dl[QB] == '0) begin
                    r_ovec[i] <= '0;
                end else if (r_dsg[QB][i]) begin
                    r_ovec[i] <= UW'(-{1'b0, r_dq[QB][i]});
                end else begin
                    r_ovec[i] <= UW'({1'b0, r_dq[QB][i]});
                end
            end
            r_opay <= r_dpay[QB];
        end
    end

    assign o_valid = r_ov;
    assign o_vec   = r_ovec;
    assign o_pay   = r_opay;

endmodule

@@ rtl/bps_light.sv @@
module bps_light (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [2:0][bps_pkg::UNIT_W-1:0]     i_n,
    input  logic [2:0][bps_pkg::UNIT_W-1:0]     i_l,
    input  logic [2:0][bps_pkg::UNIT_W-1:0]     i_h,
    input  logic [bps_pkg::TEX_W-1:0]           i_tex,
    output logic                                o_valid,
    output logic [2:0][bps_pkg::CH_W-1:0]       o_rgb
);
    localparam int PS = 10;
    localparam int FB = bps_pkg::FRAC_W;
    localparam int XW = FB + 1;

    function automatic logic [XW-1:0] dot_clamp(input logic signed [33:0] v);
        logic [33:0] m;
        logic signed [33:0] r;
        m = v[33] ? (~v + 1'b1) : v;
        m = (m + 34'd8192) >> FB;
        r = v[33] ? -$signed(m) : $signed(m);
        if (r < 0) begin
            return '0;
        end else if (r > 34'sd16384) begin
            return XW'(16384);
        end
        return XW'(r);
    endfunction

    function automatic logic [XW-1:0] qmul(input logic [XW-1:0] a, input logic [XW-1:0] b);
        logic [2*XW:0] p;
        p = (2*XW+1)'(a) * (2*XW+1)'(b) + (2*XW+1)'(8192);
        return XW'(p >> FB);
    endfunction

    logic signed [31:0]     r_pd [3];
    logic signed [31:0]     r_ph [3];
    logic [bps_pkg::TEX_W-1:0] r_ptex;
    logic                   r_pv;

    logic [XW-1:0]          r_x   [PS+1];
    logic [XW-1:0]          r_p2  [PS+1];
    logic [XW-1:0]          r_p4  [PS+1];
    logic [XW-1:0]          r_p16 [PS+1];
    logic [XW-1:0]          r_d   [PS+1];
    logic [bps_pkg::TEX_W-1:0] r_tex [PS+1];
    logic [PS:0]            r_xv;

    logic [XW-1:0]          n_x [PS+1];

    logic [2:0][22:0]       r_ca;
    logic [2:0][23:0]       r_cb;
    logic [XW-1:0]          r_cd;
    logic [XW-1:0]          r_cs;
    logic                   r_cv;
    logic [2:0][36:0]       r_ta;
    logic [2:0][38:0]       r_tb;
    logic [35:0]            r_ts;
    logic                   r_tv;
    logic [2:0][7:0]        r_rgb;
    logic                   r_ov;

    logic [2:0][40:0]       n_acc;

    always_comb begin
        n_x[0] = '0;
        for (int j = 1; j <= PS; j++) begin
            if (j <= 7) begin
                n_x[j] = qmul(r_x[j-1], r_x[j-1]);
            end else if (j == 8) begin
                n_x[j] = qmul(r_x[j-1], r_p16[j-1]);
            end else if (j == 9) begin
                n_x[j] = qmul(r_x[j-1], r_p4[j-1]);
            end else begin
                n_x[j] = qmul(r_x[j-1], r_p2[j-1]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = 41'(r_ta[c]) + 41'(r_tb[c]) + 41'(r_ts);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_xv <= '0;
            r_cv <= 1'b0;
            r_tv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
            r_xv <= {r_xv[PS-1:0], r_pv};
            r_cv <= r_xv[PS];
            r_tv <= r_cv;
            r_ov <= r_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pd[i] <= $signed(i_n[i]) * $signed(i_l[i]);
                r_ph[i] <= $signed(i_n[i]) * $signed(i_h[i]);
            end
            r_ptex <= i_tex;

            r_d[0]   <= dot_clamp(34'(r_pd[0]) + 34'(r_pd[1]) + 34'(r_pd[2]));
            r_x[0]   <= dot_clamp(34'(r_ph[0]) + 34'(r_ph[1]) + 34'(r_ph[2]));
            r_p2[0]  <= '0;
            r_p4[0]  <= '0;
            r_p16[0] <= '0;
            r_tex[0] <= r_ptex;
            for (int j = 1; j <= PS; j++) begin
                r_x[j]   <= n_x[j];
                r_p2[j]  <= (j == 1) ? n_x[j] : r_p2[j-1];
                r_p4[j]  <= (j == 2) ? n_x[j] : r_p4[j-1];
                r_p16[j] <= (j == 4) ? n_x[j] : r_p16[j-1];
                r_d[j]   <= r_d[j-1];
                r_tex[j] <= r_tex[j-1];
            end

            for (int c = 0; c < 3; c++) begin
                r_ca[c] <= 23'(r_tex[PS][23 - 8*c -: 8]) * 23'd22938;
                r_cb[c] <= 24'(r_tex[PS][23 - 8*c -: 8]) * 24'd58982;
            end
            r_cd <= r_d[PS];
            r_cs <= r_x[PS];

            for (int c = 0; c < 3; c++) begin
                r_ta[c] <= {r_ca[c], {FB{1'b0}}};
                r_tb[c] <= 39'(r_cb[c]) * 39'(r_cd);
            end
            r_ts <= 36'd2005402 * 36'(r_cs);

            for (int c = 0; c < 3; c++) begin
                r_rgb[c] <= (n_acc[c][40:30] > 11'd255) ? 8'hFF : n_acc[c][37:30];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_rgb   = r_rgb;

endmodule

@@ rtl/blinn_phong_fragment_shader.sv @@
// Channel   Dir  Handshake                 Contents
// s_axis    in   i_s_tvalid / o_s_tready   tuser: cmd, vertex_slot; tdata: corner or fragment
// m_axis    out  o_m_tvalid / i_m_tready   tdata: red, green, blue
// cfg       in   i_cfg_we                  eye and light position registers
//
// One request per cycle while the output is not stalled. A shaded fragment passes through
// two chained normalize units (square root then divide) on its way to its output register.
// Loads update the corner store at acceptance and give no output.
// Reset is synchronous, clears valid bits and corners and presets eye and light registers.
// The output register holding an untaken result stalls the whole pipeline.
module blinn_phong_fragment_shader (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, weight_a, weight_b, weight_c, texel_rgb
    input  logic [167:0]                      i_s_tdata,
    // cmd, vertex_slot
    input  logic [2:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // red, green, blue
    output logic [23:0]                       o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bps_pkg::CFG_W-1:0]         i_cfg_data
);
    localparam int VW = bps_pkg::VEC_W;
    localparam int CW = bps_pkg::COMP_W;
    localparam int UW = bps_pkg::UNIT_W;
    localparam int TW = bps_pkg::TEX_W;
    localparam int CH = bps_pkg::CH_W;
    localparam int HPW = 6 * UW + TW;

    function automatic logic [VW-1:0] rnd15(input logic signed [34:0] v);
        logic [34:0] m;
        m = v[34] ? (~v + 1'b1) : v;
        m = (m + 35'd16384) >> 15;
        return v[34] ? VW'(-m) : VW'(m);
    endfunction

    logic en;
    logic acc;
    logic cmd;
    logic [1:0] slot;

    logic signed [CW-1:0] r_eye   [3];
    logic signed [CW-1:0] r_light [3];
    logic signed [CW-1:0] r_cpos  [bps_pkg::CORNERS][3];
    logic signed [CW-1:0] r_cnrm  [bps_pkg::CORNERS][3];

    logic signed [32:0]   r_mp [3][3];
    logic signed [32:0]   r_mn [3][3];
    logic [TW-1:0]        r_mtex;
    logic                 r_mv;

    logic [2:0][VW-1:0]   r_pt;
    logic [2:0][VW-1:0]   r_nv;
    logic [TW-1:0]        r_itex;
    logic                 r_iv;

    logic [2:0][VW-1:0]   r_lv;
    logic [2:0][VW-1:0]   r_vv;
    logic [2:0][VW-1:0]   r_nn;
    logic [TW-1:0]        r_dtex;
    logic                 r_dv;

    // texel travels split: red with the normal, green with the light, blue with the view
    logic                 n_valid;
    logic [2:0][UW-1:0]   n_unit;
    logic [CH-1:0]        n_tex;
    logic                 l_valid;
    logic [2:0][UW-1:0]   l_unit;
    logic [CH-1:0]        l_tex;
    logic                 v_valid;
    logic [2:0][UW-1:0]   v_unit;
    logic [CH-1:0]        v_tex;

    logic [2:0][VW-1:0]   r_hv;
    logic [HPW-1:0]       r_hpay;
    logic                 r_hv_v;

    logic                 h_valid;
    logic [2:0][UW-1:0]   h_unit;
    logic [HPW-1:0]       h_pay;

    logic                 o_valid_int;
    logic [2:0][7:0]      rgb;

    assign en         = !o_valid_int || i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;
    assign cmd        = i_s_tuser[0];
    assign slot       = i_s_tuser[2:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_eye[i]   <= bps_pkg::EYE_RST;
                r_light[i] <= bps_pkg::LIGHT_RST;
            end
        end else if (i_cfg_we) begin
            case (bps_pkg::t_cfg_idx'(i_cfg_idx))
                bps_pkg::CFG_EYE_X:   r_eye[0]   <= i_cfg_data;
                bps_pkg::CFG_EYE_Y:   r_eye[1]   <= i_cfg_data;
                bps_pkg::CFG_EYE_Z:   r_eye[2]   <= i_cfg_data;
                bps_pkg::CFG_LIGHT_X: r_light[0] <= i_cfg_data;
                bps_pkg::CFG_LIGHT_Y: r_light[1] <= i_cfg_data;
                bps_pkg::CFG_LIGHT_Z: r_light[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < bps_pkg::CORNERS; s++) begin
                for (int i = 0; i < 3; i++) begin
                    r_cpos[s][i] <= '0;
                    r_cnrm[s][i] <= '0;
                end
            end
        end else if (acc && cmd == bps_pkg::CMD_LOAD) begin
            for (int s = 0; s < bps_pkg::CORNERS; s++) begin
                if (slot == 2'(s)) begin
                    for (int i = 0; i < 3; i++) begin
                        r_cpos[s][i] <= i_s_tdata[CW*i +: CW];
                        r_cnrm[s][i] <= i_s_tdata[CW*(i+3) +: CW];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv   <= 1'b0;
            r_iv   <= 1'b0;
            r_dv   <= 1'b0;
            r_hv_v <= 1'b0;
        end else if (en) begin
            r_mv   <= acc && cmd == bps_pkg::CMD_SHADE;
            r_iv   <= r_mv;
            r_dv   <= r_iv;
            r_hv_v <= n_valid && l_valid && v_valid;
        end
    end

    // corner weights times components, summed and rounded to Q.12
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < 3; s++) begin
                for (int i = 0; i < 3; i++) begin
                    r_mp[s][i] <= $signed({1'b0, i_s_tdata[96 + 16*s +: 16]}) * r_cpos[s][i];
                    r_mn[s][i] <= $signed({1'b0, i_s_tdata[96 + 16*s +: 16]}) * r_cnrm[s][i];
                end
            end
            r_mtex <= i_s_tdata[144 +: TW];

            for (int i = 0; i < 3; i++) begin
                r_pt[i] <= rnd15(35'(r_mp[0][i]) + 35'(r_mp[1][i]) + 35'(r_mp[2][i]));
                r_nv[i] <= rnd15(35'(r_mn[0][i]) + 35'(r_mn[1][i]) + 35'(r_mn[2][i]));
            end
            r_itex <= r_mtex;

            for (int i = 0; i < 3; i++) begin
                r_lv[i] <= VW'($signed(r_light[i])) - r_pt[i];
                r_vv[i] <= VW'($signed(r_eye[i])) - r_pt[i];
            end
            r_nn   <= r_nv;
            r_dtex <= r_itex;

            for (int i = 0; i < 3; i++) begin
                r_hv[i] <= VW'($signed(l_unit[i])) + VW'($signed(v_unit[i]));
            end
            r_hpay <= {n_unit, l_unit, n_tex, l_tex, v_tex};
        end
    end

    bps_unit #(.VW(VW), .PW(CH)) u_nrm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_dv),
        .i_vec(r_nn), .i_pay(r_dtex[TW-1 -: CH]),
        .o_valid(n_valid), .o_vec(n_unit), .o_pay(n_tex)
    );

    bps_unit #(.VW(VW), .PW(CH)) u_lgt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_dv),
        .i_vec(r_lv), .i_pay(r_dtex[CH +: CH]),
        .o_valid(l_valid), .o_vec(l_unit), .o_pay(l_tex)
    );

    bps_unit #(.VW(VW), .PW(CH)) u_view (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_dv),
        .i_vec(r_vv), .i_pay(r_dtex[CH-1:0]),
        .o_valid(v_valid), .o_vec(v_unit), .o_pay(v_tex)
    );

    bps_unit #(.VW(VW), .PW(HPW)) u_half (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_hv_v),
        .i_vec(r_hv), .i_pay(r_hpay),
        .o_valid(h_valid), .o_vec(h_unit), .o_pay(h_pay)
    );

    bps_light u_light (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(h_valid),
        .i_n(h_pay[HPW-1 -: 3*UW]), .i_l(h_pay[TW +: 3*UW]), .i_h(h_unit),
        .i_tex(h_pay[TW-1:0]),
        .o_valid(o_valid_int), .o_rgb(rgb)
    );

    assign o_m_tvalid = o_valid_int;
    assign o_m_tdata  = {rgb[2], rgb[1], rgb[0]};

endmodule
